/* hw/rtl/interlock_alarm_supervisor_top_macros.svh */
// ----------------------------------------------------------------------------
// interlock alarm supervisor assertion macros
// shared property forms for the supervisor checks
// ----------------------------------------------------------------------------
`ifndef INTERLOCK_ALARM_SUPERVISOR_TOP_MACROS_SVH
`define INTERLOCK_ALARM_SUPERVISOR_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define IAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define IAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ias_pkg.sv */
// ----------------------------------------------------------------------------
// ias_pkg
// types, codes and helpers shared by the interlock alarm supervisor
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int CFG_WIDTH          = 16;
    localparam int TIMER_WIDTH_DEF    = 16;
    localparam int LAMP_WIDTH         = 10;
    localparam int NUM_SENSORS        = 5;
    localparam int ITEM_WIDTH         = 9;
    localparam int DATA_WIDTH         = 16;
    localparam int CFG_INDEX_WIDTH    = 2;

    localparam logic [CFG_WIDTH-1:0] GRACE_TICKS_RST    = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] SHUTDOWN_DELAY_RST = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] MOTOR_STOP_RST     = 16'd100;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GRACE_TICKS    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHUTDOWN_DELAY = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MOTOR_STOP     = 2'd2;

    // timer owner codes, sensor i owns with code i+1
    localparam logic [2:0] OWNER_NONE = 3'd0;
    localparam logic [2:0] OWNER_TOP  = 3'd3;

    // lamp bit positions
    localparam int LAMP_ESTOP  = 0;
    localparam int LAMP_TEMP   = 1;
    localparam int LAMP_LOAD   = 2;
    localparam int LAMP_FLOW   = 3;
    localparam int LAMP_LEAK   = 4;
    localparam int LAMP_TOP    = 5;
    localparam int LAMP_BOTTOM = 6;
    localparam int LAMP_THIRD  = 7;
    localparam int LAMP_POS    = 8;
    localparam int LAMP_NEG    = 9;

    typedef struct packed {
        logic third_sensor_hit;
        logic upper_bottom_hit;
        logic upper_top_hit;
        logic leak_seen;
        logic flow_ok;
        logic load_ok;
        logic temp_ok;
        logic estop_ok;
        logic bypass_switch;
    } item_t;

    typedef struct packed {
        logic controller_ok;
        logic motor_enable;
        logic motor_ok;
        logic water_on;
        logic heater_on;
        logic alarm_on;
    } ctrl_t;

    localparam ctrl_t CTRL_DEFAULT = 6'h3E;

    // grace timer arbitration outcome
    typedef struct packed {
        logic [2:0] owner;
        logic       expire;
        logic       delayed;
    } arb_t;

    function automatic logic [NUM_SENSORS-1:0] sensor_faults(input item_t item);
        logic [NUM_SENSORS-1:0] f;
        begin
            f = {item.third_sensor_hit, item.upper_bottom_hit, item.upper_top_hit,
                 item.leak_seen, !item.flow_ok};
            return f;
        end
    endfunction

    function automatic logic [LAMP_WIDTH-1:0] live_lamps(input item_t item);
        logic [LAMP_WIDTH-1:0] l;
        begin
            l              = '0;
            l[LAMP_FLOW]   = !item.flow_ok;
            l[LAMP_LEAK]   = item.leak_seen;
            l[LAMP_TOP]    = item.upper_top_hit;
            l[LAMP_POS]    = item.upper_top_hit;
            l[LAMP_BOTTOM] = item.upper_bottom_hit;
            l[LAMP_NEG]    = item.upper_bottom_hit;
            l[LAMP_THIRD]  = item.third_sensor_hit;
            return l;
        end
    endfunction

endpackage

/* hw/rtl/interlock_alarm_supervisor_top.sv */
// ----------------------------------------------------------------------------
// interlock_alarm_supervisor_top
// one tick of sampled fault signals in, one lamp and control word out
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  s_tdata: sampled fault signals
// m_*       out        m_tvalid / m_tready  m_tdata: lamps and control lines
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle sustained unless m_tready stalls the output,
// an input register feeds one pass of check and timer logic into the state
// registers, which also serve as the output register
// reset returns to run with lamps off, alarm off and all other controls on
// a stalled output holds its word while one more input transaction waits
// ----------------------------------------------------------------------------
module interlock_alarm_supervisor_top
    import ias_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // bypass_switch, estop_ok, temp_ok, load_ok, flow_ok, leak_seen,
    // upper_top_hit, upper_bottom_hit, third_sensor_hit, zero pad
    input  logic [DATA_WIDTH-1:0]      s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // lamps[9:0], alarm_on, heater_on, water_on, motor_ok, motor_enable,
    // controller_ok
    output logic [DATA_WIDTH-1:0]      m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data
);

`include "interlock_alarm_supervisor_top_macros.svh"

    logic                  in_valid_reg, in_valid_next;
    item_t                 in_item_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [CFG_WIDTH-1:0]  grace_ticks_reg;
    logic [CFG_WIDTH-1:0]  shutdown_delay_reg;
    logic [CFG_WIDTH-1:0]  motor_stop_reg;
    logic                  advance;
    logic [LAMP_WIDTH-1:0] lamps;
    ctrl_t                 ctrl;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= item_t'(s_tdata[ITEM_WIDTH-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_ticks_reg    <= GRACE_TICKS_RST;
            shutdown_delay_reg <= SHUTDOWN_DELAY_RST;
            motor_stop_reg     <= MOTOR_STOP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRACE_TICKS:    grace_ticks_reg    <= cfg_data;
                CFG_SHUTDOWN_DELAY: shutdown_delay_reg <= cfg_data;
                CFG_MOTOR_STOP:     motor_stop_reg     <= cfg_data;
                default:            grace_ticks_reg    <= grace_ticks_reg;
            endcase
        end
    end

    ias_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk                  (clk),
        .rst_n                (rst_n),
        .advance              (advance),
        .item                 (in_item_reg),
        .grace_ticks          (grace_ticks_reg),
        .shutdown_delay_ticks (shutdown_delay_reg),
        .motor_stop_ticks     (motor_stop_reg),
        .lamps                (lamps),
        .ctrl                 (ctrl)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {ctrl, lamps};

    `IAS_ASSERT_NOW(a_alarm_drops_heater, ctrl.alarm_on,
                    !ctrl.heater_on && !ctrl.motor_ok,
                    "alarm raised with heater or motor permission still on")
    `IAS_ASSERT_NOW(a_halt_all_off, !ctrl.controller_ok,
                    ctrl.alarm_on && !ctrl.water_on && !ctrl.motor_enable,
                    "halted with a control line still on")
    `IAS_ASSERT_NEXT(a_halt_holds, !ctrl.controller_ok, $stable(m_tdata),
                     "output word changed after halt")

endmodule

/* hw/rtl/ias_timer_arb.sv */
// ----------------------------------------------------------------------------
// ias_timer_arb
// fixed-order arbitration of the shared grace timer and its expiry check
// ----------------------------------------------------------------------------
module ias_timer_arb
    import ias_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)
(
    input  logic [NUM_SENSORS-1:0] faults,
    input  logic [2:0]             owner_in,
    input  logic [TIMER_WIDTH-1:0] grace_in,
    input  logic [CFG_WIDTH-1:0]   grace_ticks,
    output arb_t                   arb,
    output logic [TIMER_WIDTH-1:0] grace_out
);

    localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

    logic [2:0]             owner_v;
    logic [TIMER_WIDTH-1:0] grace_v;
    logic [TIMER_WIDTH-1:0] grace_inc;
    logic [2:0]             code;
    logic                   done;

    always_comb
    begin
        owner_v     = owner_in;
        grace_v     = grace_in;
        arb.expire  = 1'b0;
        arb.delayed = 1'b0;
        done        = 1'b0;
        grace_inc   = (grace_in == '1) ? grace_in : grace_in + 1'b1;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            code = 3'(i + 1);
            if (!done)
            begin
                if (faults[i])
                begin
                    if (owner_v == OWNER_NONE)
                    begin
                        owner_v = code;
                        grace_v = '0;
                    end
                    else if (owner_v == code)
                    begin
                        grace_v = grace_inc;
                        if (CMP_WIDTH'(grace_inc) >= CMP_WIDTH'(grace_ticks))
                        begin
                            arb.expire  = 1'b1;
                            arb.delayed = (code >= OWNER_TOP);
                            done        = 1'b1;
                        end
                    end
                end
                else if (owner_v == code)
                begin
                    owner_v = OWNER_NONE;
                    grace_v = '0;
                end
            end
        end
        arb.owner = owner_v;
        grace_out = grace_v;
    end

endmodule

/* hw/rtl/ias_core.sv */
// ----------------------------------------------------------------------------
// ias_core
// supervisor state machine: run checks, shutdown sequence, lamp and control state
// ----------------------------------------------------------------------------
module ias_core
    import ias_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  item_t                 item,
    input  logic [CFG_WIDTH-1:0]  grace_ticks,
    input  logic [CFG_WIDTH-1:0]  shutdown_delay_ticks,
    input  logic [CFG_WIDTH-1:0]  motor_stop_ticks,
    output logic [LAMP_WIDTH-1:0] lamps,
    output ctrl_t                 ctrl
);

    localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

    typedef enum logic [2:0] {
        PH_RUN,
        PH_MOTOR_DELAYED,
        PH_MOTOR_IMMEDIATE,
        PH_WATER_WAIT,
        PH_HALT
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             owner_reg, owner_next;
    logic [TIMER_WIDTH-1:0] grace_reg, grace_next;
    logic [TIMER_WIDTH-1:0] delay_reg, delay_next;
    logic [TIMER_WIDTH-1:0] motor_reg, motor_next;
    logic [LAMP_WIDTH-1:0]  lamp_reg, lamp_next;
    ctrl_t                  ctrl_reg, ctrl_next;

    logic [TIMER_WIDTH-1:0] delay_inc;
    logic [TIMER_WIDTH-1:0] motor_inc;
    logic [TIMER_WIDTH-1:0] arb_grace;
    arb_t                   arb;
    logic                   start;
    logic                   start_delayed;
    logic                   halt;

    ias_timer_arb #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_timer_arb (
        .faults      (sensor_faults(item)),
        .owner_in    (owner_reg),
        .grace_in    (grace_reg),
        .grace_ticks (grace_ticks),
        .arb         (arb),
        .grace_out   (arb_grace)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        owner_next    = owner_reg;
        grace_next    = grace_reg;
        delay_next    = delay_reg;
        motor_next    = motor_reg;
        lamp_next     = lamp_reg;
        ctrl_next     = ctrl_reg;
        start         = 1'b0;
        start_delayed = 1'b0;
        halt          = 1'b0;
        delay_inc     = (delay_reg == '1) ? delay_reg : delay_reg + 1'b1;
        motor_inc     = (motor_reg == '1) ? motor_reg : motor_reg + 1'b1;
        if (advance)
        begin
            unique case (phase_reg) inside
                PH_RUN:
                begin
                    if (item.bypass_switch)
                    begin
                        ctrl_next  = CTRL_DEFAULT;
                        owner_next = OWNER_NONE;
                        grace_next = '0;
                        lamp_next  = '0;
                    end
                    if (item.bypass_switch && item.estop_ok)
                    begin
                        lamp_next            = live_lamps(item);
                        lamp_next[LAMP_TEMP] = !item.temp_ok;
                        lamp_next[LAMP_LOAD] = !item.load_ok;
                    end
                    else if (!item.estop_ok || !item.temp_ok || !item.load_ok)
                    begin
                        lamp_next[LAMP_ESTOP] = !item.estop_ok;
                        lamp_next[LAMP_TEMP]  = !item.temp_ok;
                        lamp_next[LAMP_LOAD]  = !item.load_ok;
                        start                 = 1'b1;
                        start_delayed         = 1'b1;
                    end
                    else
                    begin
                        lamp_next     = live_lamps(item);
                        owner_next    = arb.owner;
                        grace_next    = arb_grace;
                        start         = arb.expire;
                        start_delayed = arb.delayed;
                    end
                end
                PH_MOTOR_DELAYED, PH_MOTOR_IMMEDIATE:
                begin
                    motor_next = motor_inc;
                    if (phase_reg == PH_MOTOR_DELAYED)
                    begin
                        delay_next = delay_inc;
                    end
                    if (CMP_WIDTH'(motor_inc) >= CMP_WIDTH'(motor_stop_ticks))
                    begin
                        ctrl_next.motor_enable = 1'b0;
                        if (phase_reg == PH_MOTOR_IMMEDIATE ||
                            CMP_WIDTH'(delay_next) >= CMP_WIDTH'(shutdown_delay_ticks))
                        begin
                            halt = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_WATER_WAIT;
                        end
                    end
                end
                PH_WATER_WAIT:
                begin
                    delay_next = delay_inc;
                    if (CMP_WIDTH'(delay_inc) >= CMP_WIDTH'(shutdown_delay_ticks))
                    begin
                        halt = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        if (start)
        begin
            ctrl_next.alarm_on  = 1'b1;
            ctrl_next.heater_on = 1'b0;
            ctrl_next.motor_ok  = 1'b0;
            if (!start_delayed)
            begin
                ctrl_next.water_on = 1'b0;
            end
            motor_next = '0;
            delay_next = '0;
            phase_next = start_delayed ? PH_MOTOR_DELAYED : PH_MOTOR_IMMEDIATE;
        end
        if (halt)
        begin
            ctrl_next.water_on      = 1'b0;
            ctrl_next.controller_ok = 1'b0;
            phase_next              = PH_HALT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RUN;
            owner_reg <= OWNER_NONE;
            grace_reg <= '0;
            delay_reg <= '0;
            motor_reg <= '0;
            lamp_reg  <= '0;
            ctrl_reg  <= CTRL_DEFAULT;
        end
        else
        begin
            phase_reg <= phase_next;
            owner_reg <= owner_next;
            grace_reg <= grace_next;
            delay_reg <= delay_next;
            motor_reg <= motor_next;
            lamp_reg  <= lamp_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    assign lamps = lamp_reg;
    assign ctrl  = ctrl_reg;

endmodule
